>>> src/ptrb_pkg.sv
`default_nettype none
package ptrb_pkg;

   typedef enum logic [2:0] {
      ACT_ADD     = 3'd0,
      ACT_SELECT  = 3'd1,
      ACT_SUCCESS = 3'd2,
      ACT_FAILURE = 3'd3,
      ACT_TICK    = 3'd4,
      ACT_LIST    = 3'd5
   } action_type;

   typedef enum logic [1:0] {
      CSR_FIRST_DELAY = 2'd0,
      CSR_DELAY_CAP   = 2'd1,
      CSR_FAIL_LIMIT  = 2'd2
   } csr_index_type;

   typedef enum logic [1:0] {
      ST_IDLE = 2'd0,
      ST_EXEC = 2'd1,
      ST_LIST = 2'd2,
      ST_OUT  = 2'd3
   } state_type;

   typedef struct packed {
      logic [2:0]  action;
      logic [31:0] ip_addr;
      logic [15:0] port_num;
   } req_type;

   typedef struct packed {
      logic        ok;
      logic [31:0] peer_ip;
      logic [15:0] peer_port;
      logic [4:0]  entry_count;
      logic        last;
   } rsp_type;

   typedef struct packed {
      logic        add_en;
      logic        busy_en;
      logic        success_en;
      logic        failure_en;
      logic [31:0] ip_addr;
      logic [15:0] port_num;
      logic [31:0] time_now;
      logic [15:0] first_delay;
      logic [23:0] delay_cap;
      logic [7:0]  fail_limit;
   } cell_cmd_type;

   typedef struct packed {
      logic        used;
      logic        match;
      logic        eligible;
      logic        reached;
      logic [31:0] ip_addr;
      logic [15:0] port_num;
   } cell_stat_type;

   localparam logic [31:0] TIME_SAT = 32'hFFFF_FFFF;
   localparam logic [3:0]  SHIFT_CAP = 4'd7;

   function automatic logic routable(input logic [31:0] ip, input logic [15:0] port);
      logic [7:0] a;
      logic [7:0] b;
      a = ip[31:24];
      b = ip[23:16];
      routable = 1'b1;
      if (port == 16'd0) routable = 1'b0;
      if (a == 8'd0 || a == 8'd127 || a == 8'd10) routable = 1'b0;
      if (a == 8'd172 && b >= 8'd16 && b <= 8'd31) routable = 1'b0;
      if (a == 8'd192 && b == 8'd168) routable = 1'b0;
      if (a == 8'd169 && b == 8'd254) routable = 1'b0;
      if (a >= 8'd224) routable = 1'b0;
   endfunction

endpackage
`default_nettype wire

>>> src/ptrb_cell.sv
`default_nettype none
module ptrb_cell (
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire ptrb_pkg::cell_cmd_type cmd,
   input  wire logic                   sel,
   output ptrb_pkg::cell_stat_type     stat
);

   logic        used_ff;
   logic [31:0] ip_ff;
   logic [15:0] port_ff;
   logic        busy_ff;
   logic        reached_ff;
   logic [7:0]  fails_ff;
   logic [31:0] retry_ff;
   logic [7:0]  fails_in;
   logic [3:0]  shift_amt;
   logic [7:0]  fm1;
   logic [23:0] shifted;
   logic [23:0] delay;
   logic [32:0] sum;
   logic [31:0] retry_in;

   always_comb begin
      fails_in = (fails_ff == 8'hFF) ? fails_ff : fails_ff + 8'd1;
      fm1 = fails_in - 8'd1;
      shift_amt = (fm1 > 8'd7) ? ptrb_pkg::SHIFT_CAP : fm1[3:0];
      shifted = {8'd0, cmd.first_delay} << shift_amt;
      delay = (shifted > cmd.delay_cap) ? cmd.delay_cap : shifted;
      sum = {1'b0, cmd.time_now} + {9'd0, delay};
      retry_in = sum[32] ? ptrb_pkg::TIME_SAT : sum[31:0];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         used_ff <= 1'b0;
      end else if (sel && cmd.add_en) begin
         used_ff <= 1'b1;
      end
      if (sel && cmd.add_en) begin
         ip_ff      <= cmd.ip_addr;
         port_ff    <= cmd.port_num;
         busy_ff    <= 1'b0;
         reached_ff <= 1'b0;
         fails_ff   <= 8'd0;
         retry_ff   <= 32'd0;
      end else if (sel && cmd.busy_en) begin
         busy_ff <= 1'b1;
      end else if (sel && cmd.success_en) begin
         busy_ff    <= 1'b0;
         reached_ff <= 1'b1;
         fails_ff   <= 8'd0;
      end else if (sel && cmd.failure_en) begin
         busy_ff  <= 1'b0;
         fails_ff <= fails_in;
         retry_ff <= retry_in;
      end
   end

   always_comb begin
      stat.used     = used_ff;
      stat.match    = used_ff && ip_ff == cmd.ip_addr && port_ff == cmd.port_num;
      stat.eligible = used_ff && !busy_ff && fails_ff < cmd.fail_limit
                      && retry_ff <= cmd.time_now;
      stat.reached  = used_ff && reached_ff;
      stat.ip_addr  = ip_ff;
      stat.port_num = port_ff;
   end

endmodule
`default_nettype wire

>>> src/peer_table_with_retry_backoff_core.sv
// Peer table with retry backoff.
// Requests enter on the req_ channel (valid/ready) and carry an action, an
// IPv4 address and a port. Results leave on the rsp_ channel; each request
// gives one result, except list, which gives one result per reachable entry
// with last set on the final one, or a single result with ok clear.
// Every table entry is a cell holding its own address, flags, failure count
// and retry time; all cells compare against the request in parallel and a
// priority pick chooses the lowest matching slot.
// A request is accepted only when the block is idle and the result register
// is empty. The cells compare and update in the cycle after acceptance and
// the result is offered from the cycle after that. Once the result is taken
// the next request can be accepted in the cycle after. A list scans one
// slot per cycle, starting after the ST_EXEC cycle, while the receiver
// does not stall, and stops after the final reachable entry or the last
// slot. When the receiver stalls, the result holds in the output register
// and the scan waits.
// Reset clears the slot used flags and time, and loads the default
// backoff settings; there is no clearing pass. Settings are written over
// the csr_ channel, which is always ready.
`default_nettype none
module peer_table_with_retry_backoff_core #(
   parameter int TABLE_ENTRIES = 16
) (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              req_valid,
   output logic                   req_ready,
   input  wire ptrb_pkg::req_type req_data,
   output logic                   rsp_valid,
   input  wire logic              rsp_ready,
   output ptrb_pkg::rsp_type      rsp_data,
   input  wire logic              csr_valid,
   output logic                   csr_ready,
   input  wire logic [1:0]        csr_index,
   input  wire logic [31:0]       csr_wdata
);

   localparam int IW = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
   localparam int CW = $clog2(TABLE_ENTRIES + 1);

   ptrb_pkg::state_type     state_ff, state_in;
   ptrb_pkg::req_type       req_ff;
   ptrb_pkg::rsp_type       rsp_ff, rsp_in;
   logic                    rsp_valid_ff, rsp_valid_in;
   logic [15:0]             base_ff;
   logic [23:0]             maxb_ff;
   logic [7:0]              maxf_ff;
   logic [31:0]             time_ff, time_in;
   logic [IW-1:0]           scan_ff, scan_in;
   logic                    found_ff, found_in;
   ptrb_pkg::cell_cmd_type  cmd;
   ptrb_pkg::cell_stat_type stat [TABLE_ENTRIES];
   logic [TABLE_ENTRIES-1:0] sel;
   logic [TABLE_ENTRIES-1:0] used_v, match_v, elig_v;
   logic [CW-1:0]           count;
   logic [IW-1:0]           free_idx, match_idx, elig_idx;
   logic                    free_any, match_any, elig_any;
   logic [4:0]              count5;

   genvar g;
   generate
      for (g = 0; g < TABLE_ENTRIES; g++) begin : g_cell
         ptrb_cell u_cell (
            .clock (clock),
            .reset (reset),
            .cmd   (cmd),
            .sel   (sel[g]),
            .stat  (stat[g])
         );
         assign used_v[g]  = stat[g].used;
         assign match_v[g] = stat[g].match;
         assign elig_v[g]  = stat[g].eligible;
      end
   endgenerate

   always_comb begin
      count = '0;
      free_any = 1'b0; match_any = 1'b0; elig_any = 1'b0;
      free_idx = '0; match_idx = '0; elig_idx = '0;
      for (int i = TABLE_ENTRIES - 1; i >= 0; i--) begin
         count = count + CW'(used_v[i]);
         if (!used_v[i]) begin
            free_any = 1'b1; free_idx = IW'(i);
         end
         if (match_v[i]) begin
            match_any = 1'b1; match_idx = IW'(i);
         end
         if (elig_v[i]) begin
            elig_any = 1'b1; elig_idx = IW'(i);
         end
      end
   end

   assign csr_ready = 1'b1;
   assign req_ready = (state_ff == ptrb_pkg::ST_IDLE) && !rsp_valid_ff;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   always_comb begin
      logic add_go;
      add_go = ptrb_pkg::routable(req_ff.ip_addr, req_ff.port_num) && !match_any
               && free_any;
      state_in     = state_ff;
      rsp_in       = rsp_ff;
      rsp_valid_in = rsp_valid_ff;
      time_in      = time_ff;
      scan_in      = scan_ff;
      found_in     = found_ff;
      sel          = '0;
      cmd.add_en = 1'b0; cmd.busy_en = 1'b0;
      cmd.success_en = 1'b0; cmd.failure_en = 1'b0;
      cmd.ip_addr = req_ff.ip_addr;
      cmd.port_num = req_ff.port_num;
      cmd.time_now = time_ff;
      cmd.first_delay = base_ff;
      cmd.delay_cap = maxb_ff;
      cmd.fail_limit = maxf_ff;
      count5 = 5'(count);
      if (rsp_valid_ff && rsp_ready) rsp_valid_in = 1'b0;
      case (state_ff)
         ptrb_pkg::ST_IDLE: begin
            if (req_valid && req_ready) state_in = ptrb_pkg::ST_EXEC;
         end
         ptrb_pkg::ST_EXEC: begin
            rsp_in = '{ok: 1'b0, peer_ip: 32'd0, peer_port: 16'd0,
                       entry_count: count5, last: 1'b1};
            state_in = ptrb_pkg::ST_OUT;
            case (req_ff.action)
               ptrb_pkg::ACT_ADD: begin
                  if (add_go) begin
                     cmd.add_en = 1'b1;
                     sel[free_idx] = 1'b1;
                     rsp_in.ok = 1'b1;
                     rsp_in.entry_count = count5 + 5'd1;
                  end
               end
               ptrb_pkg::ACT_SELECT: begin
                  if (elig_any) begin
                     cmd.busy_en = 1'b1;
                     sel[elig_idx] = 1'b1;
                     rsp_in.ok = 1'b1;
                     rsp_in.peer_ip = stat[elig_idx].ip_addr;
                     rsp_in.peer_port = stat[elig_idx].port_num;
                  end
               end
               ptrb_pkg::ACT_SUCCESS: begin
                  if (match_any) begin
                     cmd.success_en = 1'b1;
                     sel[match_idx] = 1'b1;
                     rsp_in.ok = 1'b1;
                  end
               end
               ptrb_pkg::ACT_FAILURE: begin
                  if (match_any) begin
                     cmd.failure_en = 1'b1;
                     sel[match_idx] = 1'b1;
                     rsp_in.ok = 1'b1;
                  end
               end
               ptrb_pkg::ACT_TICK: begin
                  if (time_ff != ptrb_pkg::TIME_SAT) time_in = time_ff + 32'd1;
               end
               ptrb_pkg::ACT_LIST: begin
                  scan_in = '0;
                  found_in = 1'b0;
                  state_in = ptrb_pkg::ST_LIST;
               end
               default: begin
               end
            endcase
            if (state_in == ptrb_pkg::ST_OUT) rsp_valid_in = 1'b1;
         end
         ptrb_pkg::ST_LIST: begin
            if (!rsp_valid_in) begin
               if (stat[scan_ff].reached || 32'(scan_ff) == TABLE_ENTRIES - 1) begin
                  if (stat[scan_ff].reached) begin
                     rsp_in = '{ok: 1'b1, peer_ip: stat[scan_ff].ip_addr,
                                peer_port: stat[scan_ff].port_num,
                                entry_count: count5, last: 1'b0};
                     found_in = 1'b1;
                  end else begin
                     rsp_in = '{ok: 1'b0, peer_ip: 32'd0, peer_port: 16'd0,
                                entry_count: count5, last: 1'b1};
                  end
                  rsp_valid_in = 1'b1;
               end
               // Peek ahead so the final reached entry carries last.
               if (stat[scan_ff].reached) begin
                  rsp_in.last = 1'b1;
                  for (int j = 0; j < TABLE_ENTRIES; j++) begin
                     if (j > 32'(scan_ff) && stat[j].reached) rsp_in.last = 1'b0;
                  end
               end else if (32'(scan_ff) == TABLE_ENTRIES - 1 && found_ff) begin
                  rsp_valid_in = 1'b0;
               end
               if (rsp_valid_in && rsp_in.last) begin
                  state_in = ptrb_pkg::ST_OUT;
               end else begin
                  scan_in = scan_ff + IW'(1);
               end
            end
         end
         ptrb_pkg::ST_OUT: begin
            if (!rsp_valid_in) state_in = ptrb_pkg::ST_IDLE;
         end
         default: state_in = ptrb_pkg::ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ptrb_pkg::ST_IDLE;
         rsp_valid_ff <= 1'b0;
         time_ff      <= 32'd0;
         base_ff      <= 16'd30;
         maxb_ff      <= 24'd3600;
         maxf_ff      <= 8'd5;
         scan_ff      <= '0;
         found_ff     <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         time_ff      <= time_in;
         scan_ff      <= scan_in;
         found_ff     <= found_in;
         if (csr_valid && csr_ready) begin
            case (csr_index)
               ptrb_pkg::CSR_FIRST_DELAY: base_ff <= csr_wdata[15:0];
               ptrb_pkg::CSR_DELAY_CAP:   maxb_ff <= csr_wdata[23:0];
               ptrb_pkg::CSR_FAIL_LIMIT:  maxf_ff <= csr_wdata[7:0];
               default: begin
               end
            endcase
         end
      end
      rsp_ff <= rsp_in;
      if (req_valid && req_ready) req_ff <= req_data;
   end

endmodule
`default_nettype wire
